// ===== design/fspr_pkg.sv =====
// Package for the fixed-step PCM resampler: widths, register indexes,
// controller states, command/status structs and count conversions.
// No dependencies.
package fspr_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int FRAC_BITS      = 8;
   localparam int STEP_BITS      = 12;
   localparam int PHASE_BITS     = 13;
   localparam int SAMPLE_BITS    = 16;
   localparam int INDEX_BITS     = 24;
   localparam int CFG_COUNT_BITS = 24;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [PHASE_BITS-1:0] ONE_SAMPLE = PHASE_BITS'(1 << FRAC_BITS);
   localparam logic [STEP_BITS-1:0]  MIN_STEP   = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(256);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP,
      CSR_IN_WIDTH_16,
      CSR_OUT_WIDTH_16,
      CSR_OUT_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic last;
   } status_type;

   function automatic logic [COUNT_BITS-1:0] to_count(input logic [CFG_COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (i < CFG_COUNT_BITS) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

   function automatic logic [INDEX_BITS-1:0] to_index(input logic [COUNT_BITS-1:0] c);
      logic [INDEX_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < INDEX_BITS; i++) begin
         if (i < COUNT_BITS) begin
            r[i] = c[i];
         end
      end
      return r;
   endfunction

endpackage

// ===== design/fspr_ctrl.sv =====
// Controller for the fixed-step PCM resampler: sequences load, emit and
// finish commands for the datapath. Depends on fspr_pkg.
module fspr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                rsp_stall,
   input  fspr_pkg::status_type status,
   output fspr_pkg::cmd_type    cmd
);
   import fspr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.more) begin
               cmd.emit = 1'b1;
               state_in = ST_WAIT;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               if (status.last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.emit = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/fspr_datapath.sv =====
// Datapath for the fixed-step PCM resampler: config registers, sample
// conversion, phase and count tracking, output register. Depends on fspr_pkg.
module fspr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [fspr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fspr_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic [fspr_pkg::SAMPLE_BITS-1:0]     req_in_sample,
   input  logic                                 req_restart,
   input  logic                                 rsp_stall,
   input  fspr_pkg::cmd_type                    cmd,
   output fspr_pkg::status_type                 status,
   output logic                                 rsp_valid,
   output logic signed [fspr_pkg::SAMPLE_BITS-1:0] rsp_out_sample,
   output logic [fspr_pkg::INDEX_BITS-1:0]      rsp_out_index,
   output logic                                 rsp_last_of_run
);
   import fspr_pkg::*;

   logic [STEP_BITS-1:0]      step_ff;
   logic                      in_width_16_ff;
   logic                      out_width_16_ff;
   logic [CFG_COUNT_BITS-1:0] out_count_ff;

   logic [PHASE_BITS-1:0]     phase_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [SAMPLE_BITS-1:0]    sample_ff;

   logic                      rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]    rsp_sample_ff;
   logic [INDEX_BITS-1:0]     rsp_index_ff;
   logic                      rsp_last_ff;

   logic [STEP_BITS-1:0]      eff_step;
   logic [COUNT_BITS-1:0]     limit;
   logic [SAMPLE_BITS-1:0]    wide_sample;
   logic [SAMPLE_BITS-1:0]    conv_sample;
   logic [PHASE_BITS-1:0]     phase_next;
   logic [COUNT_BITS-1:0]     count_next;

   assign eff_step   = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   assign limit      = to_count(out_count_ff);
   assign phase_next = phase_ff + PHASE_BITS'(eff_step);
   assign count_next = count_ff + COUNT_BITS'(1);

   // 8-bit unsigned: flip the sign bit and move to the top byte
   assign wide_sample = in_width_16_ff ? req_in_sample
                                       : {~req_in_sample[7], req_in_sample[6:0], 8'h00};
   assign conv_sample = out_width_16_ff ? wide_sample
                                        : {{8{wide_sample[15]}}, wide_sample[15:8]};

   assign status.more = (phase_ff < ONE_SAMPLE) && (count_ff < limit);
   assign status.last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= STEP_RESET;
         in_width_16_ff  <= 1'b0;
         out_width_16_ff <= 1'b0;
         out_count_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP:         step_ff         <= csr_write_data[STEP_BITS-1:0];
            CSR_IN_WIDTH_16:  in_width_16_ff  <= csr_write_data[0];
            CSR_OUT_WIDTH_16: out_width_16_ff <= csr_write_data[0];
            CSR_OUT_COUNT:    out_count_ff    <= csr_write_data[CFG_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (req_restart) begin
               phase_ff <= '0;
               count_ff <= '0;
            end
         end else if (cmd.emit) begin
            phase_ff <= phase_next;
            count_ff <= count_next;
         end else if (cmd.finish) begin
            phase_ff <= (phase_ff >= ONE_SAMPLE) ? phase_ff - ONE_SAMPLE : '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= conv_sample;
      end
      if (cmd.emit) begin
         rsp_sample_ff <= sample_ff;
         rsp_index_ff  <= to_index(count_ff);
         rsp_last_ff   <= !((phase_next < ONE_SAMPLE) && (count_next < limit));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== design/fixed_step_pcm_resampler_unit.sv =====
// Top level of the fixed-step PCM resampler: controller plus datapath.
// Depends on fspr_pkg, fspr_ctrl and fspr_datapath.
//
// Usage:
//   req_ channel carries one source sample (req_in_sample, req_restart) per
//   item; rsp_ channel carries output samples with their index in the sound
//   and a flag on the last output caused by the current input.
//   csr_ port writes step (4.8), in_width_16, out_width_16 and out_count;
//   write only while the block is idle.
// Timing:
//   An input is taken while idle and evaluated in the next cycle. One
//   that makes no output then returns the block to idle; one that makes
//   outputs holds the input side until its last output is taken, one
//   output per cycle from the output register while the receiver does not
//   stall. The output register and step/count update loop set this rate.
// Reset: synchronous; clears position and count, step returns to 256,
//   widths to 8-bit, out_count to 0.
// Stall: while rsp_stall is high the current output holds and req_stall
//   stays high; work resumes on the cycle the output is taken.
module fixed_step_pcm_resampler_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [fspr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fspr_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fspr_pkg::SAMPLE_BITS-1:0]      req_in_sample,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fspr_pkg::SAMPLE_BITS-1:0] rsp_out_sample,
   output logic [fspr_pkg::INDEX_BITS-1:0]       rsp_out_index,
   output logic                                  rsp_last_of_run
);
   import fspr_pkg::*;

   cmd_type    cmd;
   status_type status;

   fspr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fspr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_in_sample    (req_in_sample),
      .req_restart      (req_restart),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_out_index    (rsp_out_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

// ===== design/fspr_checker.sv =====
// Port-level checker for the fixed-step PCM resampler, bound to the top.
// Depends on fspr_pkg and fixed_step_pcm_resampler_unit.
module fspr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [fspr_pkg::SAMPLE_BITS-1:0] rsp_out_sample,
   input logic [fspr_pkg::INDEX_BITS-1:0]       rsp_out_index,
   input logic                                  rsp_last_of_run
);
   import fspr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample)
                                 && $stable(rsp_out_index))
      else $error("stalled item changed");

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while an output is pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held after accept");

   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=>
         rsp_valid && rsp_out_index == INDEX_BITS'($past(rsp_out_index) + 1'b1))
      else $error("output run broken");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_of_run |=> !rsp_valid)
      else $error("output after last of run");

endmodule

bind fixed_step_pcm_resampler_unit fspr_checker u_fspr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_sample  (rsp_out_sample),
   .rsp_out_index   (rsp_out_index),
   .rsp_last_of_run (rsp_last_of_run)
);

// ===== dv/fixed_step_pcm_resampler_unit_test.sv =====
// Self-checking testbench for fixed_step_pcm_resampler_unit: directed and random
// source samples against an in-bench sample-and-hold resampler prediction.
// Depends on fspr_pkg and the fixed_step_pcm_resampler_unit RTL.
module fixed_step_pcm_resampler_unit_test;
   import fspr_pkg::*;

   localparam int RANDOM_ITEMS  = 220;
   localparam int MAX_RUN       = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int MAX_REPORTS   = 50;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [INDEX_BITS-1:0]         index;
      logic                          last;
   } resampled_type;

   typedef enum { STALL_NONE, STALL_RANDOM, STALL_BURSTY } stall_style_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]           csr_index = '0;
   logic [CSR_DATA_BITS-1:0]            csr_write_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [SAMPLE_BITS-1:0]              req_in_sample = '0;
   logic                                req_restart = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0]       rsp_out_sample;
   logic [INDEX_BITS-1:0]               rsp_out_index;
   logic                                rsp_last_of_run;

   // predicted block state and register copies
   logic [STEP_BITS-1:0]      cfg_step = STEP_RESET;
   logic                      cfg_in16 = 1'b0;
   logic                      cfg_out16 = 1'b0;
   logic [CFG_COUNT_BITS-1:0] cfg_out_count = '0;
   logic [PHASE_BITS-1:0]     src_phase = '0;
   logic [COUNT_BITS-1:0]     out_emitted = '0;

   resampled_type   pending_outputs[$];
   int              failures = 0;
   int              outputs_checked = 0;
   int              items_sent = 0;
   int              settings_used = 0;
   int              burst_left = 0;
   int              gap_max = 0;
   stall_style_type stall_style = STALL_NONE;
   int              hold_requests = 0;
   int              holds_served = 0;
   int              hold_left = 0;
   int              stall_tick = 0;

   fixed_step_pcm_resampler_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_sample    (req_in_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_out_index    (rsp_out_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(2 * LIMIT_CYCLES);
      $display("fixed_step_pcm_resampler_unit_test: FAIL");
      $finish;
   end

   function automatic void predict_resample(input logic [SAMPLE_BITS-1:0] raw,
                                            input logic restart);
      int            wide;
      int            narrow;
      int            phase;
      int            eff_step;
      int            n;
      resampled_type r;
      if (restart) begin
         src_phase = '0;
         out_emitted = '0;
      end
      wide = cfg_in16 ? int'($signed(raw)) : (int'(raw[7:0]) - 128) * 256;
      narrow = cfg_out16 ? wide : (wide >>> FRAC_BITS);
      eff_step = (cfg_step < MIN_STEP) ? int'(MIN_STEP) : int'(cfg_step);
      phase = int'(src_phase);
      n = 0;
      while (phase < int'(ONE_SAMPLE) && out_emitted < cfg_out_count && n < MAX_RUN) begin
         r.sample = narrow[SAMPLE_BITS-1:0];
         r.index = out_emitted;
         r.last = 1'b0;
         pending_outputs.push_back(r);
         n++;
         phase += eff_step;
         out_emitted = out_emitted + 1'b1;
      end
      if (n > 0) begin
         r = pending_outputs.pop_back();
         r.last = 1'b1;
         pending_outputs.push_back(r);
      end
      phase = (phase >= int'(ONE_SAMPLE)) ? phase - int'(ONE_SAMPLE) : 0;
      src_phase = phase[PHASE_BITS-1:0];
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_STEP:         cfg_step = value[STEP_BITS-1:0];
         CSR_IN_WIDTH_16:  cfg_in16 = value[0];
         CSR_OUT_WIDTH_16: cfg_out16 = value[0];
         CSR_OUT_COUNT:    cfg_out_count = value[CFG_COUNT_BITS-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample, input logic restart);
      if (gap_max != 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_in_sample <= sample;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      predict_resample(sample, restart);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int step, input bit in16, input bit out16, input int count);
      wait_idle();
      write_reg(CSR_STEP, CSR_DATA_BITS'(step));
      write_reg(CSR_IN_WIDTH_16, CSR_DATA_BITS'(in16));
      write_reg(CSR_OUT_WIDTH_16, CSR_DATA_BITS'(out16));
      write_reg(CSR_OUT_COUNT, CSR_DATA_BITS'(count));
      settings_used++;
   endtask

   // reset register values: count of zero gives nothing, then an 8-bit run to completion
   task automatic test_reset_defaults();
      send_sample(16'h5A5A, 1'b1);
      wait_idle();
      write_reg(CSR_OUT_COUNT, CSR_DATA_BITS'(3));
      settings_used++;
      send_sample(16'h1200, 1'b1);
      send_sample(16'hAB80, 1'b0);
      send_sample(16'h00FF, 1'b0);
      send_sample(16'h0001, 1'b0);
   endtask

   task automatic test_sample_widths();
      configure(256, 1'b1, 1'b1, 64);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      configure(256, 1'b1, 1'b0, 64);
      send_sample(16'h8000, 1'b1);
      send_sample(16'hFF7F, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      configure(256, 1'b0, 1'b1, 64);
      send_sample(16'h0000, 1'b1);
      send_sample(16'hABFF, 1'b0);
   endtask

   task automatic test_step_extremes();
      configure(4, 1'b0, 1'b1, 200);
      send_sample(16'h3C81, 1'b1);
      send_sample(16'hC37E, 1'b0);
      configure(1, 1'b1, 1'b0, 200);
      send_sample(16'h1234, 1'b1);
      configure(4095, 1'b1, 1'b1, 24'hFFFFFF);
      send_sample(16'h4321, 1'b1);
      send_sample(16'h0F0F, 1'b0);
      send_sample(16'hF0F0, 1'b0);
      send_sample(16'h5555, 1'b0);
   endtask

   // count written below the number already produced, then a restart
   task automatic test_count_lowered();
      configure(128, 1'b1, 1'b1, 10);
      send_sample(16'h1111, 1'b1);
      send_sample(16'h2222, 1'b0);
      send_sample(16'h3333, 1'b0);
      wait_idle();
      write_reg(CSR_OUT_COUNT, CSR_DATA_BITS'(3));
      settings_used++;
      send_sample(16'h4444, 1'b0);
      send_sample(16'h5555, 1'b1);
      send_sample(16'h6666, 1'b0);
   endtask

   task automatic test_backpressure();
      configure(16, 1'b1, 1'b1, 24'hFFFFFF);
      stall_style = STALL_NONE;
      gap_max = 0;
      hold_requests++;
      for (int i = 0; i < 8; i++) begin
         send_sample(16'($urandom), i == 0);
      end
   endtask

   task automatic test_random_sounds();
      int sent;
      int step;
      int count;
      int sound_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       step = $urandom_range(0, 3);
            1:       step = $urandom_range(4, 48);
            2, 3, 4: step = $urandom_range(49, 600);
            5, 6:    step = $urandom_range(601, 2000);
            default: step = $urandom_range(2001, 4095);
         endcase
         case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = 24'hFFFFFF;
            2:       count = $urandom_range(1, 8);
            default: count = $urandom_range(9, 200);
         endcase
         configure(step, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), count);
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 6;
         endcase
         stall_style = stall_style_type'($urandom_range(0, 2));
         sound_len = $urandom_range(4, 24);
         // most sounds open with a restart; a few continue the old position
         for (int i = 0; i < sound_len; i++) begin
            if (i == 0) send_sample(16'($urandom), $urandom_range(0, 9) != 0);
            else send_sample(16'($urandom), $urandom_range(0, 15) == 0);
         end
         sent += sound_len;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
               STALL_BURSTY: rsp_stall <= ((stall_tick % 11) < 4);
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_outputs
      resampled_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         outputs_checked++;
         if (pending_outputs.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected item: expected none, got sample %0d index %0d last %0b",
                        $time, rsp_out_sample, rsp_out_index, rsp_last_of_run);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_out_sample !== want.sample) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: out_sample mismatch: expected %0d, got %0d",
                           $time, want.sample, rsp_out_sample);
            end
            if (rsp_out_index !== want.index) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: out_index mismatch: expected %0d, got %0d",
                           $time, want.index, rsp_out_index);
            end
            if (rsp_last_of_run !== want.last) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_last_of_run);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_max = 3;
      stall_style = STALL_RANDOM;
      test_reset_defaults();
      test_sample_widths();
      test_step_extremes();
      test_count_lowered();
      test_backpressure();
      test_random_sounds();
      wait_idle();
      $display("Sent %0d source samples under %0d register settings; %0d outputs checked.",
               items_sent, settings_used, outputs_checked);
      $display("Covered both sample widths, step and count extremes, restarts and long stalls.");
      if (failures == 0) begin
         $display("fixed_step_pcm_resampler_unit_test: PASS");
      end else begin
         $display("fixed_step_pcm_resampler_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/fspr_pkg.sv
design/fspr_ctrl.sv
design/fspr_datapath.sv
design/fixed_step_pcm_resampler_unit.sv
design/fspr_checker.sv
dv/fixed_step_pcm_resampler_unit_test.sv
